>>> sv/slpd_pkg.sv
// Shared types and constants for the sync/length packet deframer.
package slpd_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LEN_W         = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned HEADER_LENGTH = 8;

    // Header byte positions, expressed as the remaining-byte count seen on that byte.
    localparam logic [LEN_W-1:0] HDR_REM_START = LEN_W'(HEADER_LENGTH);
    localparam logic [LEN_W-1:0] HDR_REM_SYNC1 = LEN_W'(HEADER_LENGTH - 1);
    localparam logic [LEN_W-1:0] HDR_REM_SYNC2 = LEN_W'(HEADER_LENGTH - 2);
    localparam logic [LEN_W-1:0] HDR_REM_TYPE  = LEN_W'(HEADER_LENGTH - 2);
    localparam logic [LEN_W-1:0] HDR_REM_LEN_L = LEN_W'(HEADER_LENGTH - 4);
    localparam logic [LEN_W-1:0] HDR_REM_LEN_H = LEN_W'(HEADER_LENGTH - 5);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTED_TYPE = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SYNC2   = 4'b0010,
        PH_HEADER  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] accepted_type;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

endpackage

>>> sv/slpd_in_stage.sv
// Input register stage: holds one received byte until the parser consumes it.
module slpd_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [slpd_pkg::BYTE_W-1:0] data_byte,
    input  logic                        consume,
    output logic                        held_valid,
    output logic [slpd_pkg::BYTE_W-1:0] held_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [slpd_pkg::BYTE_W-1:0] data_reg;
    logic                        load;

    // The stage takes a new beat when it is empty or its byte leaves this cycle.
    assign in_ready = !valid_reg || consume;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

>>> sv/slpd_parser.sv
// Framing state machine: sync hunt, header capture and payload counting.
module slpd_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [slpd_pkg::BYTE_W-1:0] data,
    input  slpd_pkg::cfg_t              cfg,
    output slpd_pkg::result_t           res
);

    slpd_pkg::phase_t             phase_reg;
    slpd_pkg::phase_t             phase_next;
    logic [slpd_pkg::LEN_W-1:0]   remaining_reg;
    logic [slpd_pkg::LEN_W-1:0]   remaining_next;
    logic [slpd_pkg::BYTE_W-1:0]  type_reg;
    logic [slpd_pkg::BYTE_W-1:0]  type_next;
    logic [slpd_pkg::BYTE_W-1:0]  len_lo_reg;
    logic [slpd_pkg::BYTE_W-1:0]  len_lo_next;
    logic [slpd_pkg::BYTE_W-1:0]  len_hi_reg;
    logic [slpd_pkg::BYTE_W-1:0]  len_hi_next;
    logic [slpd_pkg::LEN_W-1:0]   remaining_dec;
    logic [slpd_pkg::LEN_W-1:0]   pkt_len;

    assign remaining_dec = (remaining_reg != '0) ? (remaining_reg - 1'b1) : remaining_reg;
    assign pkt_len       = {len_hi_next, len_lo_next};

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        type_next      = type_reg;
        len_lo_next    = len_lo_reg;
        len_hi_next    = len_hi_reg;
        res            = '0;
        res.data       = data;

        case (phase_reg)
            slpd_pkg::PH_HUNT:
            begin
                if (data == cfg.sync_first)
                begin
                    phase_next     = slpd_pkg::PH_SYNC2;
                    remaining_next = slpd_pkg::HDR_REM_SYNC1;
                end
            end
            slpd_pkg::PH_SYNC2:
            begin
                if (data == cfg.sync_second)
                begin
                    phase_next     = slpd_pkg::PH_HEADER;
                    remaining_next = slpd_pkg::HDR_REM_SYNC2;
                end
                else if (data != cfg.sync_first)
                begin
                    phase_next     = slpd_pkg::PH_HUNT;
                    remaining_next = slpd_pkg::HDR_REM_START;
                end
            end
            slpd_pkg::PH_HEADER:
            begin
                if (remaining_reg == slpd_pkg::HDR_REM_TYPE)
                begin
                    type_next = data;
                end
                else if (remaining_reg == slpd_pkg::HDR_REM_LEN_L)
                begin
                    len_lo_next = data;
                end
                else if (remaining_reg == slpd_pkg::HDR_REM_LEN_H)
                begin
                    len_hi_next = data;
                end
                remaining_next = remaining_dec;
                // The length bytes just captured feed the payload count directly.
                if (remaining_dec == '0)
                begin
                    if (pkt_len == '0)
                    begin
                        phase_next     = slpd_pkg::PH_HUNT;
                        remaining_next = slpd_pkg::HDR_REM_START;
                    end
                    else
                    begin
                        phase_next     = slpd_pkg::PH_PAYLOAD;
                        remaining_next = pkt_len;
                    end
                end
            end
            slpd_pkg::PH_PAYLOAD:
            begin
                remaining_next = remaining_dec;
                res.last       = (remaining_dec == '0);
                res.valid      = (type_reg == cfg.accepted_type);
                if (remaining_dec == '0)
                begin
                    phase_next     = slpd_pkg::PH_HUNT;
                    remaining_next = slpd_pkg::HDR_REM_START;
                end
            end
            default:
            begin
                phase_next     = slpd_pkg::PH_HUNT;
                remaining_next = slpd_pkg::HDR_REM_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slpd_pkg::PH_HUNT;
            remaining_reg <= slpd_pkg::HDR_REM_START;
            type_reg      <= '0;
            len_lo_reg    <= '0;
            len_hi_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            type_reg      <= type_next;
            len_lo_reg    <= len_lo_next;
            len_hi_reg    <= len_hi_next;
        end
    end

`ifndef SYNTHESIS
    a_result_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> phase_reg == slpd_pkg::PH_PAYLOAD)
        else $error("result raised outside the payload phase");

    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == slpd_pkg::PH_HEADER |->
            (remaining_reg != '0) && (remaining_reg <= slpd_pkg::HDR_REM_SYNC2))
        else $error("header byte count out of range");

    a_payload_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == slpd_pkg::PH_PAYLOAD |-> remaining_reg != '0)
        else $error("payload phase with zero bytes remaining");

    a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.last |=>
            phase_reg == slpd_pkg::PH_HUNT && remaining_reg == slpd_pkg::HDR_REM_START)
        else $error("final payload byte did not return the parser to hunting");
`endif

endmodule

>>> sv/slpd_out_stage.sv
// Result register: holds one payload beat until the receiver takes it.
module slpd_out_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  slpd_pkg::result_t           res,
    output logic                        can_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [slpd_pkg::BYTE_W-1:0] payload_byte,
    output logic                        last_of_packet
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [slpd_pkg::BYTE_W-1:0] data_reg;
    logic                        last_reg;

    // The register may be refilled when it is empty or its beat leaves now.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            data_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign out_valid      = valid_reg;
    assign payload_byte   = data_reg;
    assign last_of_packet = last_reg;

endmodule

>>> sv/sync_length_packet_deframer_core.sv
// Top level of the sync-word, length-prefixed packet deframer.
//
// The input channel (in_valid, in_ready, data_byte) carries one stream byte
// per beat. The block hunts for the two-byte sync word, collects the rest of
// the fixed-length header, reads the packet type from header byte 2 and the
// payload length, low byte first, from header bytes 4 and 5. Payload bytes of
// a packet whose type equals accepted_type leave on the output channel
// (out_valid, out_ready, payload_byte, last_of_packet), with last_of_packet
// set on the final byte; payload of other packets is consumed silently.
// A byte flows through an input register and then the framing logic into the
// result register, which holds a payload beat until the receiver takes it.
// One byte is accepted every cycle as long as the receiver keeps up.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; after that in_ready drops until the
// result is taken. Reset clears both registers and the configuration, and
// puts the framer back to hunting for the first sync byte. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Unused indexes are ignored.
module sync_length_packet_deframer_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [slpd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [slpd_pkg::BYTE_W-1:0]    payload_byte,
    output logic                           last_of_packet,
    input  logic                           cfg_we,
    input  logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slpd_pkg::BYTE_W-1:0]    cfg_data
);

    slpd_pkg::cfg_t              cfg_reg;
    slpd_pkg::cfg_t              cfg_next;
    logic                        held_valid;
    logic [slpd_pkg::BYTE_W-1:0] held_data;
    logic                        can_load;
    logic                        consume;
    slpd_pkg::result_t           res;

    // Configuration registers, written in place.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                slpd_pkg::CFG_SYNC_FIRST:    cfg_next.sync_first    = cfg_data;
                slpd_pkg::CFG_SYNC_SECOND:   cfg_next.sync_second   = cfg_data;
                slpd_pkg::CFG_ACCEPTED_TYPE: cfg_next.accepted_type = cfg_data;
                default:                     cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A held byte is processed whenever the result register can take its outcome.
    assign consume = held_valid && can_load;

    slpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .consume    (consume),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    slpd_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (consume),
        .data  (held_data),
        .cfg   (cfg_reg),
        .res   (res)
    );

    slpd_out_stage u_out_stage
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (consume),
        .res            (res),
        .can_load       (can_load),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .last_of_packet (last_of_packet)
    );

endmodule
